[hdl/fss_pkg.sv]
// Shared constants, result types and saturation helper for the forward
// substitution solver. No dependencies.
`timescale 1ns / 1ps

package fss_pkg;

    localparam int DATA_W    = 32;   // Q16.16 operand width
    localparam int FRAC_W    = 16;   // fraction bits of Q16.16
    localparam int ACC_W     = 64;   // Q32.32 accumulator width
    localparam int INDEX_W   = 10;   // width of the emitted row number
    localparam int SIZE_W    = 11;   // width of the system size register

    localparam int                 DEFAULT_MAX_UNKNOWNS = 1024;
    localparam logic [SIZE_W-1:0]  SIZE_RESET           = SIZE_W'(1024);

    localparam logic signed [ACC_W-1:0]  ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0]  ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Largest quotient magnitudes that still fit the result in each sign
    localparam logic [ACC_W-1:0] Q_POS_LIM =
        {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] Q_NEG_LIM = Q_POS_LIM + ACC_W'(1);

    typedef struct packed {
        logic                    ovf;
        logic signed [ACC_W-1:0] value;
    } sat_sum_t;

    // Clamp a one-bit-wider sum or difference to the accumulator range.
    function automatic sat_sum_t sat_acc(input logic [ACC_W:0] wide);
        sat_sum_t r;
        r.ovf = (wide[ACC_W] != wide[ACC_W-1]);
        if (r.ovf) begin
            r.value = wide[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            r.value = wide[ACC_W-1:0];
        end
        return r;
    endfunction

endpackage

[hdl/forward_substitution_solver_unit.sv]
// Forward-substitution solver for a lower-triangular system, top level.
// Depends on fss_pkg (widths, saturation helper).
`timescale 1ns / 1ps

// Solves L x = b one unknown at a time. Send the coefficients of L row by
// row over the s_ channel, columns 0..i for row i, with b_i in s_rhs_value on
// the diagonal transfer (s_rhs_value is ignored elsewhere). Every diagonal
// transfer yields one result on the m_ channel: x_i in signed Q16.16, its row
// number, a zero_pivot flag (diagonal was zero, value forced to 0), a
// saturated flag (an accumulate, the numerator or the quotient was clamped)
// and system_done on the last row, after which the row count wraps to 0.
// Writing cfg_data sets the number of unknowns (0 acts as 1, values above
// MAX_UNKNOWNS act as MAX_UNKNOWNS) and restarts the system at row 0.
// Timing: an off-diagonal coefficient passes the solution store read and the
// 32x32 multiply, then the accumulate, which overlaps the next transfer. A
// diagonal coefficient passes the numerator step, the radix-2 divider that
// retires one quotient bit per cycle over the 64-bit numerator (skipped on a
// zero pivot) and the finish step, which waits for a free output slot; no
// transfer is taken meanwhile. Solutions live in a single-port-write,
// single-port-read store of MAX_UNKNOWNS words with a registered read; it
// needs no clearing: row i reads only columns solved earlier in the system.
module forward_substitution_solver_unit #(
    parameter int MAX_UNKNOWNS = fss_pkg::DEFAULT_MAX_UNKNOWNS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fss_pkg::SIZE_W-1:0]        cfg_data,
    // coefficient channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [fss_pkg::DATA_W-1:0] s_coefficient,
    input  logic signed [fss_pkg::DATA_W-1:0] s_rhs_value,
    // solution channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [fss_pkg::DATA_W-1:0] m_solution_value,
    output logic [fss_pkg::INDEX_W-1:0]       m_solution_index,
    output logic                              m_zero_pivot,
    output logic                              m_saturated,
    output logic                              m_system_done
);
    import fss_pkg::*;

    localparam int IDX_W   = (MAX_UNKNOWNS > 1) ? $clog2(MAX_UNKNOWNS) : 1;
    localparam int CMP_W   = (IDX_W + 1 > SIZE_W + 1) ? IDX_W + 1 : SIZE_W + 1;
    localparam int ROWX_W  = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;
    localparam int DCNT_W  = $clog2(ACC_W);
    localparam int SIGN_W  = ACC_W - DATA_W - FRAC_W;

    typedef enum logic [2:0] {
        ST_IDLE,   // wait for a transfer
        ST_MUL,    // store word is back: multiply
        ST_ACC,    // accumulate product, may take the next transfer
        ST_NUM,    // form numerator and operand magnitudes
        ST_DIV,    // one quotient bit per cycle
        ST_FIN     // saturate, store and emit once the output slot frees
    } state_t;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                    state_reg,  state_next;
    logic [SIZE_W-1:0]         size_reg,   size_next;
    logic [IDX_W-1:0]          col_reg,    col_next;
    logic [IDX_W-1:0]          row_reg,    row_next;
    logic signed [ACC_W-1:0]   acc_reg,    acc_next;
    logic                      ovf_reg,    ovf_next;
    logic [DCNT_W-1:0]         dcnt_reg,   dcnt_next;

    // payload, no reset needed
    logic signed [DATA_W-1:0]  coef_reg,   coef_next;
    logic signed [DATA_W-1:0]  rhs_reg,    rhs_next;
    logic signed [ACC_W-1:0]   prod_reg,   prod_next;
    logic                      zp_reg,     zp_next;
    logic                      neg_reg,    neg_next;
    logic                      ovfd_reg,   ovfd_next;
    logic [ACC_W-1:0]          dq_reg,     dq_next;    // dividend in, quotient out
    logic [DATA_W-1:0]         ud_reg,     ud_next;    // divisor magnitude
    logic [DATA_W-1:0]         rem_reg,    rem_next;

    logic                      m_valid_reg,  m_valid_next;
    logic signed [DATA_W-1:0]  m_value_reg,  m_value_next;
    logic [INDEX_W-1:0]        m_index_reg,  m_index_next;
    logic                      m_zp_reg,     m_zp_next;
    logic                      m_sat_reg,    m_sat_next;
    logic                      m_done_reg,   m_done_next;

    // solution store
    logic signed [DATA_W-1:0]  store_mem [MAX_UNKNOWNS];
    logic signed [DATA_W-1:0]  rd_data_reg;

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic                      s_xfer;
    logic                      cfg_xfer;
    logic                      is_diag;
    logic                      rd_en;
    logic                      wr_en;
    logic signed [DATA_W-1:0]  fin_value;
    logic                      fin_sat;
    logic [CMP_W-1:0]          eff_size;
    logic                      row_last;
    logic signed [ACC_W-1:0]   rhs_q;
    sat_sum_t                  acc_sum;
    sat_sum_t                  num_sum;
    logic [ACC_W-1:0]          num_bits;
    logic [DATA_W:0]           rem_sh;
    logic                      rem_ge;
    logic [ROWX_W-1:0]         row_ext;

    // In idle, accept only when no config write is pending, so a restart never
    // races an item; config writes are taken only in idle.
    assign s_ready   = (state_reg == ST_ACC) || ((state_reg == ST_IDLE) && !cfg_valid);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_xfer    = s_valid && s_ready;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign is_diag   = (col_reg == row_reg);
    assign rd_en     = s_xfer && !is_diag;

    assign m_valid          = m_valid_reg;
    assign m_solution_value = m_value_reg;
    assign m_solution_index = m_index_reg;
    assign m_zero_pivot     = m_zp_reg;
    assign m_saturated      = m_sat_reg;
    assign m_system_done    = m_done_reg;

    // Clamp the configured size into 1..MAX_UNKNOWNS.
    always_comb begin
        if (size_reg == '0) begin
            eff_size = CMP_W'(1);
        end else if (CMP_W'(size_reg) > CMP_W'(MAX_UNKNOWNS)) begin
            eff_size = CMP_W'(MAX_UNKNOWNS);
        end else begin
            eff_size = CMP_W'(size_reg);
        end
    end

    assign row_last = (CMP_W'(row_reg) + CMP_W'(1)) >= eff_size;
    assign row_ext  = ROWX_W'(row_reg);

    // Q16.16 rhs aligned to Q32.32
    assign rhs_q    = {{SIGN_W{rhs_reg[DATA_W-1]}}, rhs_reg, {FRAC_W{1'b0}}};
    assign acc_sum  = sat_acc({acc_reg[ACC_W-1], acc_reg} + {prod_reg[ACC_W-1], prod_reg});
    assign num_sum  = sat_acc({rhs_q[ACC_W-1], rhs_q} - {acc_reg[ACC_W-1], acc_reg});
    assign num_bits = num_sum.value;

    // restoring divider step
    assign rem_sh = {rem_reg, dq_reg[ACC_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, ud_reg});

    // Final quotient: sign, clamp to Q16.16
    always_comb begin
        fin_value = '0;
        fin_sat   = ovfd_reg;
        if (zp_reg) begin
            fin_value = '0;
        end else if (neg_reg) begin
            if (dq_reg > Q_NEG_LIM) begin
                fin_value = DATA_MIN;
                fin_sat   = 1'b1;
            end else begin
                fin_value = DATA_W'(ACC_W'(0) - dq_reg);
            end
        end else begin
            if (dq_reg > Q_POS_LIM) begin
                fin_value = DATA_MAX;
                fin_sat   = 1'b1;
            end else begin
                fin_value = DATA_W'(dq_reg);
            end
        end
    end

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        size_next    = size_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        acc_next     = acc_reg;
        ovf_next     = ovf_reg;
        dcnt_next    = dcnt_reg;
        coef_next    = coef_reg;
        rhs_next     = rhs_reg;
        prod_next    = prod_reg;
        zp_next      = zp_reg;
        neg_next     = neg_reg;
        ovfd_next    = ovfd_reg;
        dq_next      = dq_reg;
        ud_next      = ud_reg;
        rem_next     = rem_reg;
        m_valid_next = m_valid_reg;
        m_value_next = m_value_reg;
        m_index_next = m_index_reg;
        m_zp_next    = m_zp_reg;
        m_sat_next   = m_sat_reg;
        m_done_next  = m_done_reg;
        wr_en        = 1'b0;

        // drop the result once it is transferred
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
            end
            ST_MUL: begin
                prod_next  = coef_reg * rd_data_reg;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                acc_next   = acc_sum.value;
                ovf_next   = ovf_reg | acc_sum.ovf;
                state_next = ST_IDLE;
            end
            ST_NUM: begin
                zp_next   = (coef_reg == '0);
                neg_next  = num_bits[ACC_W-1] ^ coef_reg[DATA_W-1];
                dq_next   = num_bits[ACC_W-1] ? (ACC_W'(0) - num_bits) : num_bits;
                ud_next   = coef_reg[DATA_W-1] ? (DATA_W'(0) - DATA_W'(coef_reg))
                                               : DATA_W'(coef_reg);
                rem_next  = '0;
                dcnt_next = '0;
                // a zero pivot skips the numerator, so its clamp does not count
                ovfd_next = ovf_reg | ((coef_reg != '0) && num_sum.ovf);
                state_next = (coef_reg == '0) ? ST_FIN : ST_DIV;
            end
            ST_DIV: begin
                rem_next  = rem_ge ? DATA_W'(rem_sh - {1'b0, ud_reg}) : rem_sh[DATA_W-1:0];
                dq_next   = {dq_reg[ACC_W-2:0], rem_ge};
                dcnt_next = dcnt_reg + DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(ACC_W - 1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                // hold until the output slot is free
                if (!m_valid_reg || m_ready) begin
                    wr_en        = 1'b1;
                    m_valid_next = 1'b1;
                    m_value_next = fin_value;
                    m_index_next = row_ext[INDEX_W-1:0];
                    m_zp_next    = zp_reg;
                    m_sat_next   = fin_sat;
                    m_done_next  = row_last;
                    acc_next     = '0;
                    ovf_next     = 1'b0;
                    col_next     = '0;
                    row_next     = row_last ? '0 : row_reg + IDX_W'(1);
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // take a coefficient: off-diagonal reads the store, diagonal divides
        if (s_xfer) begin
            coef_next = s_coefficient;
            rhs_next  = s_rhs_value;
            if (is_diag) begin
                state_next = ST_NUM;
            end else begin
                col_next   = col_reg + IDX_W'(1);
                state_next = ST_MUL;
            end
        end

        // a size write restarts the system
        if (cfg_xfer) begin
            size_next = cfg_data;
            col_next  = '0;
            row_next  = '0;
            acc_next  = '0;
            ovf_next  = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // State and registered outputs
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            size_reg    <= SIZE_RESET;
            col_reg     <= '0;
            row_reg     <= '0;
            acc_reg     <= '0;
            ovf_reg     <= 1'b0;
            dcnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            size_reg    <= size_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            acc_reg     <= acc_next;
            ovf_reg     <= ovf_next;
            dcnt_reg    <= dcnt_next;
            m_valid_reg <= m_valid_next;
        end
        coef_reg    <= coef_next;
        rhs_reg     <= rhs_next;
        prod_reg    <= prod_next;
        zp_reg      <= zp_next;
        neg_reg     <= neg_next;
        ovfd_reg    <= ovfd_next;
        dq_reg      <= dq_next;
        ud_reg      <= ud_next;
        rem_reg     <= rem_next;
        m_value_reg <= m_value_next;
        m_index_reg <= m_index_next;
        m_zp_reg    <= m_zp_next;
        m_sat_reg   <= m_sat_next;
        m_done_reg  <= m_done_next;
    end

    // ------------------------------------------------------------------
    // Solution store: write on emit, read at transfer of an off-diagonal
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[row_reg] <= fin_value;
        end
        if (rd_en) begin
            rd_data_reg <= store_mem[col_reg];
        end
    end

`ifndef NO_ASSERTIONS
    a_col_within_row: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg <= row_reg)
        else $error("column count ran past the row");

    a_row_within_size: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(row_reg) < eff_size)
        else $error("row count outside the system size");

    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result raised outside the finish step");

    a_zero_pivot_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_zp_reg) |-> (m_value_reg == '0))
        else $error("zero pivot with a nonzero value");

    a_wrap_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_valid_reg) && m_done_reg) |-> (row_reg == '0))
        else $error("row count did not wrap after the last unknown");

    a_no_read_write_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(rd_en && wr_en))
        else $error("store read and write in the same cycle");
`endif

endmodule
